>>> hw/rtl/wed_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard edit distance package
// Shared widths, wildcard codes, and the structures used by the cell chain.
// ----------------------------------------------------------------------------
package wed_pkg;

    localparam int DIST_W      = 8;
    localparam int SYM_W       = 8;
    localparam int MAX_LEN_DEF = 128;

    localparam logic [SYM_W-1:0]  STAR_BYTE   = 8'd42;
    localparam logic [SYM_W-1:0]  QMARK_BYTE  = 8'd63;
    localparam logic [DIST_W-1:0] LIMIT_RESET = 8'd40;

    typedef logic [DIST_W-1:0] dist_t;

    // Wavefront token handed from one cell to the next.
    typedef struct packed {
        logic  valid;
        logic  inc;
        dist_t new_val;
        dist_t old_val;
        dist_t min_val;
        dist_t first_min;
    } cell_tok_t;

    // Row operation broadcast to every cell while a row is swept.
    typedef struct packed {
        logic             first;
        logic             present;
        logic             star;
        logic [SYM_W-1:0] sym;
        logic             sub_cost;
        logic             gap_cost;
    } row_op_t;

    function automatic dist_t sat_dist(input logic [DIST_W:0] v);
        dist_t r;
        r = v[DIST_W] ? '1 : v[DIST_W-1:0];
        return r;
    endfunction

    function automatic dist_t min_dist(input dist_t a, input dist_t b);
        dist_t r;
        r = (a < b) ? a : b;
        return r;
    endfunction

endpackage

>>> hw/rtl/wildcard_edit_distance_unit.sv
// ----------------------------------------------------------------------------
// Wildcard edit distance unit
// Compares a stored word against a streamed pattern with '?' and '*' wildcards.
// Input words carry kind, symbol, has_symbol and last under valid/ready; a word
// is taken on an edge where in_valid and in_ready are both high.  Word bytes
// (kind 0) are loaded as they arrive and stay until the next word starts.
// A pattern byte (kind 1) launches a row update down a chain of MAX_LEN-1
// cells, one cell per cycle, unless the row count is at its bound or the limit
// is already exceeded; in_ready stays low until the row leaves the chain.  On
// the last pattern word the result word (distance, over_limit) is presented
// after that row update, if any, and an emit step.  The result sits in an
// output register under out_valid/out_ready; while the receiver stalls, the
// unit keeps taking inputs until it has another result to present.
// cfg_write_en writes distance_limit from cfg_write_data.  After reset the
// limit is 40, the word is empty and complete, and no result is pending;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module wildcard_edit_distance_unit #(
    parameter int MAX_LEN = wed_pkg::MAX_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  symbol,
    input  logic        has_symbol,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  distance,
    output logic        over_limit
);

    localparam int LEN_W = $clog2(MAX_LEN);
    localparam int DW    = wed_pkg::DIST_W;
    localparam int SUM_W = DW + 1;
    localparam logic [LEN_W-1:0] LEN_LAST  = LEN_W'(MAX_LEN - 1);
    localparam logic [DW-1:0]    OVER_DIST = DW'(MAX_LEN % (2 ** DW));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    wed_pkg::dist_t     limit_reg, limit_next;
    logic [LEN_W-1:0]   word_len_reg, word_len_next;
    logic               word_done_reg, word_done_next;
    logic [LEN_W-1:0]   pat_cnt_reg, pat_cnt_next;
    logic               over_reg, over_next;
    logic               last_reg, last_next;
    wed_pkg::dist_t     d0_reg, d0_next;
    wed_pkg::dist_t     tail_reg, tail_next;
    wed_pkg::row_op_t   op_reg, op_next;
    wed_pkg::cell_tok_t launch_reg, launch_next;
    logic               out_valid_reg, out_valid_next;
    wed_pkg::dist_t     out_dist_reg, out_dist_next;
    logic               out_over_reg, out_over_next;

    wed_pkg::cell_tok_t tok_bus [MAX_LEN];
    wed_pkg::cell_tok_t chain_end;
    logic [LEN_W-1:0]   len_base;
    logic [LEN_W-1:0]   load_pos;
    logic               load_en;
    logic               is_star;
    logic               is_qmark;
    wed_pkg::row_op_t   row_op_in;
    wed_pkg::dist_t     d0_first;
    wed_pkg::dist_t     d0_step;
    wed_pkg::dist_t     row_min;
    logic               start;
    logic               start_first;

    assign in_ready  = (state_reg == ST_IDLE);
    assign len_base  = word_done_reg ? '0 : word_len_reg;
    assign load_pos  = len_base + LEN_W'(1);
    assign load_en   = in_valid && in_ready && !kind && has_symbol && (len_base < LEN_LAST);

    assign is_star  = has_symbol && (symbol == wed_pkg::STAR_BYTE);
    assign is_qmark = has_symbol && (symbol == wed_pkg::QMARK_BYTE);

    assign row_op_in.first    = start_first;
    assign row_op_in.present  = has_symbol;
    assign row_op_in.star     = is_star;
    assign row_op_in.sym      = symbol;
    assign row_op_in.sub_cost = !(is_star || is_qmark);
    assign row_op_in.gap_cost = !is_star;

    assign d0_first = (has_symbol && !is_star) ? DW'(1) : '0;
    assign d0_step  = wed_pkg::sat_dist({1'b0, d0_reg} + SUM_W'(!is_star));

    assign chain_end = tok_bus[MAX_LEN-1];
    assign row_min   = op_reg.first ? chain_end.first_min : chain_end.min_val;

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        word_len_next  = word_len_reg;
        word_done_next = word_done_reg;
        pat_cnt_next   = pat_cnt_reg;
        over_next      = over_reg;
        last_next      = last_reg;
        d0_next        = d0_reg;
        tail_next      = tail_reg;
        op_next        = op_reg;
        launch_next       = launch_reg;
        launch_next.valid = 1'b0;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_over_next  = out_over_reg;
        start          = 1'b0;
        start_first    = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_write_en)
        begin
            limit_next = cfg_write_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!kind)
                    begin
                        if (word_done_reg)
                        begin
                            pat_cnt_next   = '0;
                            over_next      = 1'b0;
                            word_done_next = 1'b0;
                        end
                        word_len_next = len_base;
                        if (load_en)
                        begin
                            word_len_next = load_pos;
                        end
                        if (last)
                        begin
                            word_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        word_done_next = 1'b1;
                        last_next      = last;
                        if (has_symbol && (pat_cnt_reg < LEN_LAST))
                        begin
                            pat_cnt_next = pat_cnt_reg + LEN_W'(1);
                            if (pat_cnt_reg == '0)
                            begin
                                start       = 1'b1;
                                start_first = 1'b1;
                            end
                            else if (!over_reg)
                            begin
                                start = 1'b1;
                            end
                        end
                        else if (last && (pat_cnt_reg == '0))
                        begin
                            start       = 1'b1;
                            start_first = 1'b1;
                        end

                        if (start)
                        begin
                            op_next                = row_op_in;
                            d0_next                = start_first ? d0_first : d0_step;
                            launch_next.valid      = 1'b1;
                            launch_next.inc        = !is_qmark;
                            launch_next.new_val    = d0_next;
                            launch_next.old_val    = d0_reg;
                            launch_next.min_val    = d0_next;
                            launch_next.first_min  = d0_next;
                            state_next             = ST_SWEEP;
                        end
                        else if (last)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                if (chain_end.valid)
                begin
                    tail_next = chain_end.new_val;
                    if (row_min > limit_reg)
                    begin
                        over_next = 1'b1;
                    end
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (over_reg || (tail_reg > limit_reg))
                    begin
                        out_dist_next = OVER_DIST;
                        out_over_next = 1'b1;
                    end
                    else
                    begin
                        out_dist_next = tail_reg;
                        out_over_next = 1'b0;
                    end
                    pat_cnt_next = '0;
                    over_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= wed_pkg::LIMIT_RESET;
            word_len_reg  <= '0;
            word_done_reg <= 1'b1;
            pat_cnt_reg   <= '0;
            over_reg      <= 1'b0;
            last_reg      <= 1'b0;
            d0_reg        <= '0;
            tail_reg      <= '0;
            op_reg        <= '0;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_dist_reg  <= '0;
            out_over_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            word_len_reg  <= word_len_next;
            word_done_reg <= word_done_next;
            pat_cnt_reg   <= pat_cnt_next;
            over_reg      <= over_next;
            last_reg      <= last_next;
            d0_reg        <= d0_next;
            tail_reg      <= tail_next;
            op_reg        <= op_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            out_dist_reg  <= out_dist_next;
            out_over_reg  <= out_over_next;
        end
    end

    assign tok_bus[0] = launch_reg;

    for (genvar k = 1; k < MAX_LEN; k++)
    begin : g_cell
        wed_cell #(
            .MAX_LEN (MAX_LEN),
            .IDX     (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (op_reg),
            .word_len (word_len_reg),
            .load_en  (load_en),
            .load_pos (load_pos),
            .load_sym (symbol),
            .tok_in   (tok_bus[k-1]),
            .tok_out  (tok_bus[k])
        );
    end

    assign out_valid  = out_valid_reg;
    assign distance   = out_dist_reg;
    assign over_limit = out_over_reg;

`ifndef SYNTHESIS
    a_end_only_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chain_end.valid |-> (state_reg == ST_SWEEP))
        else $error("Row finished outside of a sweep.");

    a_launch_enters_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg.valid |-> (state_reg == ST_SWEEP))
        else $error("Row launched without entering a sweep.");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("Result presented without an emit step.");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (pat_cnt_reg <= LEN_LAST) && (word_len_reg <= LEN_LAST))
        else $error("Pattern count or word length beyond the length bound.");
`endif

endmodule

>>> hw/rtl/wed_cell.sv
// ----------------------------------------------------------------------------
// Wildcard edit distance cell
// Holds one word byte and its row entry, and updates the entry as the token passes.
// ----------------------------------------------------------------------------
module wed_cell #(
    parameter int MAX_LEN = wed_pkg::MAX_LEN_DEF,
    parameter int IDX     = 1,
    localparam int LEN_W  = $clog2(MAX_LEN)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wed_pkg::row_op_t           op,
    input  logic [LEN_W-1:0]           word_len,
    input  logic                       load_en,
    input  logic [LEN_W-1:0]           load_pos,
    input  logic [wed_pkg::SYM_W-1:0]  load_sym,
    input  wed_pkg::cell_tok_t         tok_in,
    output wed_pkg::cell_tok_t         tok_out
);

    localparam int DW    = wed_pkg::DIST_W;
    localparam int SUM_W = DW + 1;
    localparam logic [LEN_W-1:0] POS     = LEN_W'(IDX);
    localparam logic [DW-1:0]    FR_BASE = DW'(IDX - 1);

    logic [wed_pkg::SYM_W-1:0] word_reg, word_next;
    wed_pkg::dist_t            dist_reg, dist_next;
    wed_pkg::cell_tok_t        tok_reg, tok_next;

    logic                      match;
    logic                      active;
    logic                      inc_here;
    wed_pkg::dist_t            first_val;
    wed_pkg::dist_t            row_val;
    logic [SUM_W-1:0]          diag_sum;
    logic [SUM_W-1:0]          up_sum;
    logic [SUM_W-1:0]          left_sum;
    logic [SUM_W-1:0]          best_a;
    logic [SUM_W-1:0]          best;

    assign match     = (op.sym == word_reg);
    assign active    = (POS <= word_len);
    assign inc_here  = tok_in.inc & ~(op.present & match);
    assign first_val = op.star ? '0 : (FR_BASE + DW'(inc_here));

    assign diag_sum = {1'b0, tok_in.old_val} + SUM_W'(match ? 1'b0 : op.sub_cost);
    assign up_sum   = {1'b0, dist_reg} + SUM_W'(op.gap_cost);
    assign left_sum = {1'b0, tok_in.new_val} + SUM_W'(op.gap_cost);
    assign best_a   = (diag_sum < up_sum) ? diag_sum : up_sum;
    assign best     = (best_a < left_sum) ? best_a : left_sum;
    assign row_val  = op.first ? first_val : wed_pkg::sat_dist(best);

    always_comb
    begin
        tok_next       = tok_reg;
        tok_next.valid = 1'b0;
        dist_next      = dist_reg;
        word_next      = word_reg;
        if (load_en && (load_pos == POS))
        begin
            word_next = load_sym;
        end
        if (tok_in.valid)
        begin
            if (active)
            begin
                dist_next        = row_val;
                tok_next.valid   = 1'b1;
                tok_next.inc     = inc_here;
                tok_next.new_val = row_val;
                tok_next.old_val = dist_reg;
                tok_next.min_val = wed_pkg::min_dist(tok_in.min_val, row_val);
                if ((IDX == 1) && (tok_in.first_min != '0))
                begin
                    tok_next.first_min = row_val;
                end
                else
                begin
                    tok_next.first_min = tok_in.first_min;
                end
            end
            else
            begin
                // Positions past the word pass the finished row value along.
                tok_next = tok_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        dist_reg <= dist_next;
    end

    assign tok_out = tok_reg;

endmodule
